// ----- rtl/core/crp_pkg.sv -----
// Package for the table-assignment sampler: state machine type, field widths.
// No dependencies.
package crp_pkg;
   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
   localparam logic KIND_RESAMPLE = 1'b0;
   localparam logic KIND_PRESET = 1'b1;
   localparam logic [0:0] REG_DISCOUNT = 1'b0;
   localparam logic [0:0] REG_MASS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ_ITEM, ST_TAKE_OFF, ST_SUM, ST_DECIDE,
      ST_SCALE, ST_SEARCH, ST_SEAT, ST_DONE
   } state_type;
endpackage

// ----- rtl/core/crp_table_assignment_sampler.sv -----
// Top level of the table-assignment sampler: item store, count store, sequencer.
// Depends on crp_pkg.
//
//  channel | handshake             | payload
//  req     | start & !busy         | kind, item_index, draw_select, draw_pick, preset_table
//  rsp     | rsp_valid (one cycle) | assigned_table, opened_new, overflow
//  csr     | psel&penable&pwrite   | discount (addr 0), new_table_mass (addr 4)
//
// A resample item that joins an existing table keeps busy high through two passes:
// one pass over the count memory sums weights, a second searches the running sum, one read
// a cycle. One that opens a new table skips the search. A preset item skips both passes.
// The result shows in the same cycle in which busy falls. After reset a clearing pass runs
// over both memories with busy high. The receiver cannot stall: each result shows for one
// cycle.
module crp_table_assignment_sampler #(
   parameter int MAX_TABLES = 256,
   parameter int MAX_ITEMS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [11:0] req_item_index,
   input  logic [31:0] req_draw_select,
   input  logic [31:0] req_draw_pick,
   input  logic [8:0]  req_preset_table,
   output logic        rsp_valid,
   output logic [8:0]  rsp_assigned_table,
   output logic        rsp_opened_new,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int TW = $clog2(MAX_TABLES);
   localparam int IW = $clog2(MAX_ITEMS);
   localparam int SW = $clog2(MAX_TABLES + 1);
   localparam int CW = crp_pkg::COUNT_W;
   localparam int CLRW = (TW > IW) ? TW : IW;
   localparam logic [SW-1:0] TABLES_S = SW'(MAX_TABLES);

   // Configuration registers.
   logic [15:0] discount_ff;
   logic [31:0] mass_ff;
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= 16'd0;
         mass_ff <= 32'd65536;
      end else if (cfg_wr) begin
         if (paddr[2] == crp_pkg::REG_DISCOUNT) discount_ff <= pwdata[15:0];
         else mass_ff <= pwdata;
      end
   end
   always_comb begin
      if (paddr[1:0] != 2'd0) prdata = 32'd0;
      else if (paddr[2] == crp_pkg::REG_DISCOUNT) prdata = {16'd0, discount_ff};
      else prdata = mass_ff;
   end

   // Memories.
   logic [SW-1:0] item_mem [MAX_ITEMS];
   logic [CW-1:0] cnt_mem [MAX_TABLES];
   logic [SW-1:0] item_rd_ff;
   logic [CW-1:0] cnt_rd_ff;
   logic item_we, cnt_we;
   logic [IW-1:0] item_addr;
   logic [SW-1:0] item_wd;
   logic [TW-1:0] cnt_raddr, cnt_waddr;
   logic [CW-1:0] cnt_wd;
   always_ff @(posedge clock) begin
      if (item_we) item_mem[item_addr] <= item_wd;
      item_rd_ff <= item_mem[item_addr];
   end
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // Sequencer registers.
   crp_pkg::state_type state_ff, state_in;
   logic [CLRW:0] clr_ff, clr_in;
   logic          kind_ff;
   logic [IW-1:0] item_ff;
   logic [31:0]   d1_ff, d2_ff;
   logic [8:0]    preset_ff;
   logic [SW:0]   k_ff, k_in;         // read pointer, one ahead of the data
   logic [63:0]   s_ff, s_in, acc_ff, acc_in;
   logic [63:0]   pos_ff, pos_in;
   logic [SW-1:0] empty_ff, empty_in; // first empty table plus one, 0 none
   logic [SW-1:0] pick_ff, pick_in;
   logic          found_ff, found_in;
   logic [1:0]    ph_ff, ph_in;
   logic [63:0]   ta_ff, ta_in, tb_ff, tb_in;
   logic          exist_ff, exist_in;
   logic [SW-1:0] res_ff, res_in;
   logic          opn_ff, opn_in, ovf_ff, ovf_in, val_ff, val_in;

   logic [TW-1:0] kdata;
   logic [63:0]   weight;
   logic [63:0]   tsum;
   logic [SW-1:0] seat_t;

   assign kdata = TW'(k_ff - 1'b1);
   assign weight = (cnt_rd_ff == '0) ? 64'd0 :
                   ({35'd0, cnt_rd_ff, 16'd0} - {48'd0, discount_ff});
   assign tsum = s_ff + {32'd0, mass_ff};
   assign seat_t = exist_ff ? pick_ff : empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crp_pkg::ST_CLEAR;
         clr_ff <= '0;
         val_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         val_ff <= val_in;
      end
      k_ff <= k_in; s_ff <= s_in; acc_ff <= acc_in; pos_ff <= pos_in;
      empty_ff <= empty_in; pick_ff <= pick_in; found_ff <= found_in;
      ph_ff <= ph_in; ta_ff <= ta_in; tb_ff <= tb_in; exist_ff <= exist_in;
      res_ff <= res_in; opn_ff <= opn_in; ovf_ff <= ovf_in;
      if (start && !busy) begin
         kind_ff <= req_kind;
         item_ff <= IW'(req_item_index);
         d1_ff <= req_draw_select;
         d2_ff <= req_draw_pick;
         preset_ff <= req_preset_table;
      end
   end

   assign busy = (state_ff != crp_pkg::ST_IDLE);

   // Next state, memory control.
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; k_in = k_ff; s_in = s_ff;
      acc_in = acc_ff; pos_in = pos_ff; empty_in = empty_ff; pick_in = pick_ff;
      found_in = found_ff; ph_in = ph_ff; ta_in = ta_ff; tb_in = tb_ff;
      exist_in = exist_ff; res_in = res_ff; opn_in = opn_ff; ovf_in = ovf_ff;
      val_in = 1'b0;
      item_we = 1'b0; item_addr = item_ff; item_wd = '0;
      cnt_we = 1'b0; cnt_raddr = kdata; cnt_waddr = kdata; cnt_wd = '0;
      unique case (state_ff)
         crp_pkg::ST_CLEAR: begin
            item_we = (clr_ff < (CLRW+1)'(MAX_ITEMS));
            item_addr = IW'(clr_ff);
            cnt_we = (clr_ff < (CLRW+1)'(MAX_TABLES));
            cnt_waddr = TW'(clr_ff);
            clr_in = clr_ff + 1'b1;
            if (!item_we && !cnt_we) state_in = crp_pkg::ST_IDLE;
         end
         crp_pkg::ST_IDLE: begin
            item_addr = IW'(req_item_index);
            if (start) begin
               if ({20'd0, req_item_index} >= 32'(MAX_ITEMS)) begin
                  res_in = '0; opn_in = 1'b0; ovf_in = 1'b0;
                  state_in = crp_pkg::ST_DONE;
               end else state_in = crp_pkg::ST_READ_ITEM;
            end
         end
         crp_pkg::ST_READ_ITEM: begin
            // Item entry is back; fetch the old table's count.
            cnt_raddr = TW'(item_rd_ff - 1'b1);
            state_in = crp_pkg::ST_TAKE_OFF;
         end
         crp_pkg::ST_TAKE_OFF: begin
            cnt_waddr = TW'(item_rd_ff - 1'b1);
            cnt_wd = cnt_rd_ff - 1'b1;
            cnt_we = (item_rd_ff != '0) && (item_rd_ff <= TABLES_S) && (cnt_rd_ff != '0);
            item_we = 1'b1;
            item_wd = '0;
            opn_in = 1'b0; ovf_in = 1'b0;
            if (kind_ff == crp_pkg::KIND_PRESET) begin
               res_in = '0;
               if (preset_ff != 9'd0 && {{(32-9){1'b0}}, preset_ff} <= 32'(MAX_TABLES)) begin
                  exist_in = 1'b1;
                  pick_in = SW'(preset_ff);
                  state_in = crp_pkg::ST_SEAT;
                  ph_in = 2'd0;
               end else state_in = crp_pkg::ST_DONE;
            end else begin
               k_in = '0; s_in = '0; empty_in = '0;
               state_in = crp_pkg::ST_SUM;
               ph_in = 2'd0;
            end
         end
         crp_pkg::ST_SUM: begin
            // One count per cycle; data lags the pointer by one.
            cnt_raddr = TW'(k_ff);
            if (k_ff != '0) begin
               s_in = s_ff + weight;
               if (cnt_rd_ff == '0 && empty_ff == '0) empty_in = SW'(k_ff);
            end
            k_in = k_ff + 1'b1;
            if (k_ff == (SW+1)'(MAX_TABLES)) begin
               state_in = crp_pkg::ST_DECIDE;
               ph_in = 2'd0;
            end
         end
         crp_pkg::ST_DECIDE: begin
            // d1*T split in two 32x32 products, formed in phase 0 and summed in phase 1.
            if (ph_ff == 2'd0) begin
               ta_in = {32'd0, d1_ff} * {32'd0, tsum[63:32]};
               tb_in = {32'd0, d1_ff} * {32'd0, tsum[31:0]};
               ph_in = 2'd1;
            end else begin
               exist_in = (ta_ff + {32'd0, tb_ff[63:32]}) < s_ff;
               state_in = crp_pkg::ST_SCALE;
               ph_in = 2'd0;
            end
         end
         crp_pkg::ST_SCALE: begin
            if (!exist_ff) begin
               state_in = crp_pkg::ST_SEAT;
            end else if (ph_ff == 2'd0) begin
               ta_in = {32'd0, d2_ff} * {32'd0, s_ff[63:32]};
               tb_in = {32'd0, d2_ff} * {32'd0, s_ff[31:0]};
               ph_in = 2'd1;
            end else begin
               pos_in = ta_ff + {32'd0, tb_ff[63:32]};
               k_in = '0; acc_in = '0; found_in = 1'b0;
               pick_in = TABLES_S;
               state_in = crp_pkg::ST_SEARCH;
            end
            if (state_in == crp_pkg::ST_SEAT) ph_in = 2'd0;
         end
         crp_pkg::ST_SEARCH: begin
            cnt_raddr = TW'(k_ff);
            if (k_ff != '0 && !found_ff) begin
               acc_in = acc_ff + weight;
               if (acc_ff + weight > pos_ff) begin
                  found_in = 1'b1;
                  pick_in = SW'(k_ff);
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == (SW+1)'(MAX_TABLES)) begin
               state_in = crp_pkg::ST_SEAT;
               ph_in = 2'd0;
            end
         end
         crp_pkg::ST_SEAT: begin
            // Read the chosen count, then write item and count back.
            cnt_raddr = TW'(seat_t - 1'b1);
            cnt_waddr = TW'(seat_t - 1'b1);
            if (!exist_ff && empty_ff == '0) begin
               res_in = '0; ovf_in = 1'b1;
               state_in = crp_pkg::ST_DONE;
            end else if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else begin
               cnt_wd = cnt_rd_ff + 1'b1;
               cnt_we = (cnt_rd_ff != crp_pkg::COUNT_MAX);
               item_we = 1'b1;
               item_wd = seat_t;
               res_in = seat_t;
               opn_in = !exist_ff;
               state_in = crp_pkg::ST_DONE;
            end
         end
         crp_pkg::ST_DONE: begin
            val_in = 1'b1;
            state_in = crp_pkg::ST_IDLE;
         end
         default: state_in = crp_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = val_ff;
   assign rsp_assigned_table = 9'(res_ff);
   assign rsp_opened_new = opn_ff;
   assign rsp_overflow = ovf_ff;

   // A result appears only right after the done state.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == crp_pkg::ST_DONE)) else $error("stray result");
   // Overflow and a new table exclude each other.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_opened_new && rsp_overflow)) else $error("flag clash");
   // Overflow leaves the item unassigned.
   a_ovf_unassigned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_assigned_table == 9'd0))
      else $error("overflow with table");
endmodule
